>>> src/cbts_pkg.sv
package cbts_pkg;

  localparam int unsigned CLOCK_WIDTH_DEF = 32;
  localparam int unsigned RATE_W = 24;
  localparam int unsigned BRP_W = 10;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  localparam int unsigned MIN_QUANTA = 3;
  localparam int unsigned SPLIT_NUM = 3;
  localparam int unsigned SPLIT_DEN = 4;

  localparam logic [BRP_W-1:0] BRP_MIN_RST = 10'd1;
  localparam logic [BRP_W-1:0] BRP_MAX_RST = 10'd1023;
  localparam logic [BRP_W-1:0] BRP_STEP_RST = 10'd1;
  localparam logic [SEG_W-1:0] SEG_MIN_RST = 8'd1;
  localparam logic [SEG_W-1:0] SEG_MAX_RST = 8'd255;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_ZERO_RATE = 2'd1,
    ST_NO_CLOCK  = 2'd2,
    ST_NO_FIT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CLOCK_HZ = 3'd0,
    REG_BRP_MIN  = 3'd1,
    REG_BRP_MAX  = 3'd2,
    REG_BRP_STEP = 3'd3,
    REG_SEG1_MIN = 3'd4,
    REG_SEG1_MAX = 3'd5,
    REG_SEG2_MIN = 3'd6,
    REG_SEG2_MAX = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LOOP,
    S_DIV1,
    S_WAIT1,
    S_SEG,
    S_FIT,
    S_DIV2,
    S_WAIT2,
    S_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [BRP_W-1:0] prescaler_min;
    logic [BRP_W-1:0] prescaler_max;
    logic [BRP_W-1:0] prescaler_step;
    logic [SEG_W-1:0] seg1_min;
    logic [SEG_W-1:0] seg1_max;
    logic [SEG_W-1:0] seg2_min;
    logic [SEG_W-1:0] seg2_max;
  } cfg_t;

  typedef struct packed {
    logic    load_req;
    logic    mul_rate;
    logic    div_start;
    logic    seg;
    logic    fit;
    logic    step;
    logic    load_res;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic clock_zero;
    logic brp_over;
    logic div_busy;
    logic tq_low;
    logic fit_ok;
    logic match;
  } dp_sts_t;

endpackage

>>> src/cbts_if.sv
interface cbts_req_if import cbts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] bitrate;

  modport source (output valid, output bitrate, input ready);
  modport sink (input valid, input bitrate, output ready);
endinterface

interface cbts_rsp_if import cbts_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [BRP_W-1:0] prescaler;
  logic [SEG_W-1:0] seg1_tq;
  logic [SEG_W-1:0] seg2_tq;

  modport source (output valid, output status, output prescaler, output seg1_tq,
                  output seg2_tq, input ready);
  modport sink (input valid, input status, input prescaler, input seg1_tq,
                input seg2_tq, output ready);
endinterface

>>> src/cbts_regs.sv
module cbts_regs import cbts_pkg::*; #(
  parameter int unsigned CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg,
  output logic [CLOCK_WIDTH-1:0] clock_hz
);

  reg_idx_t         idx;
  logic             wr;
  logic [BRP_W-1:0] v10;
  logic [SEG_W-1:0] v8;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign v10    = pwdata[BRP_W-1:0];
  assign v8     = pwdata[SEG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz           <= '0;
      cfg.prescaler_min  <= BRP_MIN_RST;
      cfg.prescaler_max  <= BRP_MAX_RST;
      cfg.prescaler_step <= BRP_STEP_RST;
      cfg.seg1_min       <= SEG_MIN_RST;
      cfg.seg1_max       <= SEG_MAX_RST;
      cfg.seg2_min       <= SEG_MIN_RST;
      cfg.seg2_max       <= SEG_MAX_RST;
    end else if (wr) begin
      unique case (idx)
        REG_CLOCK_HZ: clock_hz <= pwdata[CLOCK_WIDTH-1:0];
        // zero minimum and zero step both store one
        REG_BRP_MIN:  cfg.prescaler_min <= (v10 == '0) ? BRP_MIN_RST : v10;
        REG_BRP_MAX:  cfg.prescaler_max <= v10;
        REG_BRP_STEP: cfg.prescaler_step <= (v10 == '0) ? BRP_STEP_RST : v10;
        REG_SEG1_MIN: cfg.seg1_min <= v8;
        REG_SEG1_MAX: cfg.seg1_max <= v8;
        REG_SEG2_MIN: cfg.seg2_min <= v8;
        REG_SEG2_MAX: cfg.seg2_max <= v8;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLOCK_HZ: prdata = DATA_W'(clock_hz);
      REG_BRP_MIN:  prdata = DATA_W'(cfg.prescaler_min);
      REG_BRP_MAX:  prdata = DATA_W'(cfg.prescaler_max);
      REG_BRP_STEP: prdata = DATA_W'(cfg.prescaler_step);
      REG_SEG1_MIN: prdata = DATA_W'(cfg.seg1_min);
      REG_SEG1_MAX: prdata = DATA_W'(cfg.seg1_max);
      REG_SEG2_MIN: prdata = DATA_W'(cfg.seg2_min);
      REG_SEG2_MAX: prdata = DATA_W'(cfg.seg2_max);
    endcase
  end

endmodule

>>> src/cbts_div.sv
module cbts_div import cbts_pkg::*; #(
  parameter int unsigned CLOCK_WIDTH = CLOCK_WIDTH_DEF,
  parameter int unsigned DIVISOR_W = RATE_W + BRP_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CLOCK_WIDTH-1:0] dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output logic                   busy,
  output logic [CLOCK_WIDTH-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(CLOCK_WIDTH + 1);

  logic [DIVISOR_W:0]   rem;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 take;
  logic [CNT_W-1:0]     cnt;

  // one quotient bit a cycle, dividend bits shift out of the top of quot
  assign rem_sh  = {rem[DIVISOR_W-1:0], quot[CLOCK_WIDTH-1]};
  assign take    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(CLOCK_WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= take ? rem_sub : rem_sh;
      quot <= {quot[CLOCK_WIDTH-2:0], take};
    end
  end

endmodule

>>> src/cbts_dp.sv
module cbts_dp import cbts_pkg::*; #(
  parameter int unsigned CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic [CLOCK_WIDTH-1:0] clock_hz,
  input  logic [RATE_W-1:0]      bitrate,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output status_t                res_status,
  output logic [BRP_W-1:0]       res_prescaler,
  output logic [SEG_W-1:0]       res_seg1,
  output logic [SEG_W-1:0]       res_seg2
);

  localparam int unsigned PROD_A_W = RATE_W + BRP_W;
  localparam int unsigned PROD_B_W = CLOCK_WIDTH + BRP_W;
  localparam int unsigned DVW = (PROD_A_W > PROD_B_W) ? PROD_A_W : PROD_B_W;
  localparam int unsigned CMP_W = (RATE_W > CLOCK_WIDTH) ? RATE_W : CLOCK_WIDTH;

  logic [RATE_W-1:0]      rate;
  logic [BRP_W:0]         brp;
  logic [DVW-1:0]         divisor;
  logic [SEG_W-1:0]       s1;
  logic [SEG_W-1:0]       s2;

  logic                   div_busy;
  logic [CLOCK_WIDTH-1:0] quot;
  logic [PROD_A_W-1:0]    prod_a;
  logic [PROD_B_W-1:0]    prod_b;
  logic [CLOCK_WIDTH-1:0] total;
  logic [CLOCK_WIDTH+1:0] tri3;
  logic [CLOCK_WIDTH-1:0] s1_raw;
  logic [CLOCK_WIDTH-1:0] s1_lo;
  logic [CLOCK_WIDTH-1:0] s1_clamp;
  logic [CLOCK_WIDTH-1:0] s2_full;
  logic                   s1_over;

  cbts_div #(
    .CLOCK_WIDTH (CLOCK_WIDTH),
    .DIVISOR_W   (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (clock_hz),
    .divisor  (divisor),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign prod_a = rate * brp[BRP_W-1:0];
  assign prod_b = quot * brp[BRP_W-1:0];

  // quot holds tq from the first division until the second one starts
  assign total  = quot - 1'b1;
  assign tri3   = (CLOCK_WIDTH+2)'(total) * (CLOCK_WIDTH+2)'(SPLIT_NUM);
  assign s1_raw = CLOCK_WIDTH'(tri3 / SPLIT_DEN);
  assign s1_lo  = (s1_raw < CLOCK_WIDTH'(cfg.seg1_min)) ? CLOCK_WIDTH'(cfg.seg1_min) : s1_raw;
  // the upper clamp comes last and wins when the bounds cross
  assign s1_clamp = (s1_lo > CLOCK_WIDTH'(cfg.seg1_max)) ? CLOCK_WIDTH'(cfg.seg1_max) : s1_lo;

  assign s1_over = CLOCK_WIDTH'(s1) > total;
  assign s2_full = total - CLOCK_WIDTH'(s1);

  assign sts.rate_zero  = rate == '0;
  assign sts.clock_zero = clock_hz == '0;
  assign sts.brp_over   = brp > {1'b0, cfg.prescaler_max};
  assign sts.div_busy   = div_busy;
  assign sts.tq_low     = quot < CLOCK_WIDTH'(MIN_QUANTA);
  assign sts.fit_ok     = !s1_over && (s2_full >= CLOCK_WIDTH'(cfg.seg2_min))
                          && (s2_full <= CLOCK_WIDTH'(cfg.seg2_max));
  assign sts.match      = CMP_W'(quot) == CMP_W'(rate);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rate <= bitrate;
      brp  <= {1'b0, cfg.prescaler_min};
    end else if (cmd.step) begin
      brp <= brp + {1'b0, cfg.prescaler_step};
    end
    if (cmd.mul_rate) begin
      divisor <= DVW'(prod_a);
    end else if (cmd.seg) begin
      divisor <= DVW'(prod_b);
    end
    if (cmd.seg) begin
      s1 <= s1_clamp[SEG_W-1:0];
    end
    if (cmd.fit) begin
      s2 <= s2_full[SEG_W-1:0];
    end
    if (cmd.load_res) begin
      res_status <= cmd.res_status;
      if (cmd.res_status == ST_FOUND) begin
        res_prescaler <= brp[BRP_W-1:0];
        res_seg1      <= s1;
        res_seg2      <= s2;
      end else begin
        res_prescaler <= '0;
        res_seg1      <= '0;
        res_seg2      <= '0;
      end
    end
  end

endmodule

>>> src/cbts_ctrl.sv
module cbts_ctrl import cbts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= ST_FOUND;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.load_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    code_next      = code;
    req_ready      = 1'b0;
    cmd            = '0;
    cmd.res_status = code;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.rate_zero) begin
          code_next  = ST_ZERO_RATE;
          state_next = S_FINISH;
        end else if (sts.clock_zero) begin
          code_next  = ST_NO_CLOCK;
          state_next = S_FINISH;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.brp_over) begin
          code_next  = ST_NO_FIT;
          state_next = S_FINISH;
        end else begin
          cmd.mul_rate = 1'b1;
          state_next   = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (!sts.div_busy) begin
          state_next = S_SEG;
        end
      end
      S_SEG: begin
        // tq never grows with the prescaler, so too few quanta ends the search
        if (sts.tq_low) begin
          code_next  = ST_NO_FIT;
          state_next = S_FINISH;
        end else begin
          cmd.seg    = 1'b1;
          state_next = S_FIT;
        end
      end
      S_FIT: begin
        if (sts.fit_ok) begin
          cmd.fit    = 1'b1;
          state_next = S_DIV2;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT2;
      end
      S_WAIT2: begin
        if (!sts.div_busy) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          code_next  = ST_FOUND;
          state_next = S_FINISH;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/can_bit_timing_search.sv
// CAN bit timing search: each request carries a bitrate, and the block walks the
// baud rate prescaler from prescaler_min to prescaler_max in prescaler_step,
// returning the first prescaler with its segment 1 and segment 2 split that gives
// the bitrate exactly, or a status for zero bitrate, unknown clock or no fit.
// One request is in work at a time. Each prescaler tried costs one pass of a
// shared radix-2 divider plus the control states; a prescaler whose segments fit
// takes a second pass through the divider. At most 1023 prescalers are tried per
// request. The search stops early once the quanta per bit fall below three.
// The next request is taken while the previous response still waits in the
// output register.
module can_bit_timing_search import cbts_pkg::*; #(
  parameter int unsigned CLOCK_WIDTH = CLOCK_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  cbts_req_if.sink          req,
  cbts_rsp_if.source        rsp
);

  cfg_t                   cfg;
  logic [CLOCK_WIDTH-1:0] clock_hz;
  dp_cmd_t                cmd;
  dp_sts_t                sts;

  cbts_regs #(
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .clock_hz (clock_hz)
  );

  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbts_dp #(
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .clock_hz      (clock_hz),
    .bitrate       (req.bitrate),
    .cmd           (cmd),
    .sts           (sts),
    .res_status    (rsp.status),
    .res_prescaler (rsp.prescaler),
    .res_seg1      (rsp.seg1_tq),
    .res_seg2      (rsp.seg2_tq)
  );

endmodule

>>> sim/testbench.sv
module testbench import cbts_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    status_t          status;
    logic [BRP_W-1:0] prescaler;
    logic [SEG_W-1:0] seg1_tq;
    logic [SEG_W-1:0] seg2_tq;
  } timing_t;

  class timing_scoreboard;
    logic [31:0] clock_hz;
    int unsigned brp_min, brp_max, brp_step;
    int unsigned seg1_min, seg1_max, seg2_min, seg2_max;
    timing_t     expected_timings[$];
    int unsigned errors;

    function new();
      clock_hz = '0;
      brp_min  = BRP_MIN_RST;
      brp_max  = BRP_MAX_RST;
      brp_step = BRP_STEP_RST;
      seg1_min = SEG_MIN_RST;
      seg1_max = SEG_MAX_RST;
      seg2_min = SEG_MIN_RST;
      seg2_max = SEG_MAX_RST;
      errors   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_CLOCK_HZ: clock_hz = value;
        REG_BRP_MIN:  brp_min = (value[9:0] == '0) ? 1 : value[9:0];
        REG_BRP_MAX:  brp_max = value[9:0];
        REG_BRP_STEP: brp_step = (value[9:0] == '0) ? 1 : value[9:0];
        REG_SEG1_MIN: seg1_min = value[7:0];
        REG_SEG1_MAX: seg1_max = value[7:0];
        REG_SEG2_MIN: seg2_min = value[7:0];
        REG_SEG2_MAX: seg2_max = value[7:0];
        default: ;
      endcase
    endfunction

    function timing_t find_timing(logic [RATE_W-1:0] rate);
      timing_t         t;
      longint unsigned tq, total, s1, s2;
      int unsigned     brp;
      bit              done;
      t = '0;
      done = 0;
      if (rate == '0) begin
        t.status = ST_ZERO_RATE;
      end else if (clock_hz == '0) begin
        t.status = ST_NO_CLOCK;
      end else begin
        t.status = ST_NO_FIT;
        for (brp = brp_min; brp <= brp_max && !done; brp += brp_step) begin
          tq = 64'(clock_hz) / (64'(rate) * 64'(brp));
          if (tq >= MIN_QUANTA) begin
            total = tq - 1;
            s1 = total * SPLIT_NUM / SPLIT_DEN;
            if (s1 < seg1_min) s1 = seg1_min;
            // upper clamp last, so it wins over crossed bounds
            if (s1 > seg1_max) s1 = seg1_max;
            if (s1 <= total) begin
              s2 = total - s1;
              if (s2 >= seg2_min && s2 <= seg2_max &&
                  64'(clock_hz) / (64'(brp) * (1 + s1 + s2)) == 64'(rate)) begin
                t.status    = ST_FOUND;
                t.prescaler = brp[BRP_W-1:0];
                t.seg1_tq   = s1[SEG_W-1:0];
                t.seg2_tq   = s2[SEG_W-1:0];
                done = 1;
              end
            end
          end
        end
      end
      return t;
    endfunction

    function void note_request(logic [RATE_W-1:0] rate);
      expected_timings.push_back(find_timing(rate));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(timing_t got);
      timing_t want;
      if (expected_timings.size() == 0) begin
        $display("%0t: response with no request waiting, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_timings.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("prescaler", want.prescaler, got.prescaler);
        compare_field("seg1_tq", want.seg1_tq, got.seg1_tq);
        compare_field("seg2_tq", want.seg2_tq, got.seg2_tq);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cbts_req_if req_bus ();
  cbts_rsp_if rsp_bus ();

  timing_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned pattern_left = 0;
  int unsigned ready_pct = 100;
  int unsigned idle_cycles = 0;

  can_bit_timing_search uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_bus),
    .rsp     (rsp_bus)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // response side stalls in stretches of varying duty
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_response(timing_t'{rsp_bus.status, rsp_bus.prescaler,
                                    rsp_bus.seg1_tq, rsp_bus.seg2_tq});
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 30;
          default: ready_pct = 5;
        endcase
      end
      pattern_left--;
      rsp_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] noisy(logic [31:0] value, int unsigned width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    return (($urandom_range(0, 1) == 1) ? ($urandom & ~mask) : 32'd0) | (value & mask);
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_timing(input logic [31:0] clock_hz, input int unsigned bmin,
                            input int unsigned bmax, input int unsigned bstep,
                            input int unsigned s1lo, input int unsigned s1hi,
                            input int unsigned s2lo, input int unsigned s2hi);
    apb_write(REG_CLOCK_HZ, clock_hz);
    apb_write(REG_BRP_MIN, noisy(bmin, BRP_W));
    apb_write(REG_BRP_MAX, noisy(bmax, BRP_W));
    apb_write(REG_BRP_STEP, noisy(bstep, BRP_W));
    apb_write(REG_SEG1_MIN, noisy(s1lo, SEG_W));
    apb_write(REG_SEG1_MAX, noisy(s1hi, SEG_W));
    apb_write(REG_SEG2_MIN, noisy(s2lo, SEG_W));
    apb_write(REG_SEG2_MAX, noisy(s2hi, SEG_W));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_rate(input logic [RATE_W-1:0] rate);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_bus.valid   <= 1'b1;
    req_bus.bitrate <= rate;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(rate);
  endtask

  // block is idle once every response is in
  task automatic settle();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_timings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic directed_checks();
    // reset settings, clock still unknown: zero rate must win over no clock
    send_rate(0);
    send_rate(1);
    send_rate(24'hFFFFFF);
    settle();

    // full prescaler range at 80 MHz
    set_timing(80000000, 1, 1023, 1, 1, 255, 1, 255);
    send_rate(0);
    send_rate(1);
    send_rate(500000);
    send_rate(1000000);
    send_rate(125000);
    send_rate(24'hFFFFFF);
    send_rate(33333);
    settle();

    // zero minimum and zero step both store one
    set_timing(32'hFFFFFFFF, 0, 8, 0, 1, 255, 1, 255);
    send_rate(24'hFFFFFF);
    send_rate(1);
    send_rate(255);
    send_rate(1000000);
    settle();

    // top prescaler only, all segment bounds at the top
    set_timing(80000000, 1023, 1023, 1023, 255, 255, 255, 255);
    send_rate(153);
    send_rate(154);
    send_rate(1);
    settle();

    // crossed segment 1 bounds
    set_timing(80000000, 1, 4, 1, 200, 10, 1, 255);
    send_rate(1000000);
    settle();

    // segment 1 minimum leaves no room for segment 2
    set_timing(80000000, 1, 4, 1, 200, 255, 1, 255);
    send_rate(1000000);
    settle();

    // minimum above maximum
    set_timing(80000000, 10, 5, 1, 1, 255, 1, 255);
    send_rate(1000000);
    settle();
  endtask

  task automatic random_phase(input int unsigned n_requests);
    logic [31:0]   clock_hz;
    logic [63:0]   rate;
    int unsigned   bmin, bmax, bstep, s1lo, s1hi, s2lo, s2hi, brp, tq;
    case ($urandom_range(0, 5))
      0: clock_hz = $urandom;
      1: clock_hz = 80000000;
      2: clock_hz = 40000000;
      3: clock_hz = 16000000;
      4: clock_hz = 32'hFFFFFFFF;
      default: clock_hz = $urandom_range(1, 200) * 1000000;
    endcase
    bmin  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 64);
    bstep = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 4);
    // keep the number of prescalers tried small so searches stay short
    bmax = bmin + bstep * $urandom_range(0, 40);
    if (bmax > 1023) bmax = 1023;
    if ($urandom_range(0, 9) == 0 && bmin > 1) bmax = $urandom_range(1, bmin - 1);
    if ($urandom_range(0, 9) == 0) bmin = 0;
    if ($urandom_range(0, 9) == 0) bstep = 0;
    s1lo = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
    s1hi = $urandom_range(4, 255);
    s2lo = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
    s2hi = $urandom_range(2, 255);
    set_timing(clock_hz, bmin, bmax, bstep, s1lo, s1hi, s2lo, s2hi);

    repeat (n_requests) begin
      case ($urandom_range(0, 9))
        0: rate = $urandom & 32'hFFFFFF;
        1: rate = $urandom_range(1, 2000);
        default: begin
          // aim at a prescaler in range and a whole number of quanta
          brp = sb.brp_min + sb.brp_step * $urandom_range(0, 40);
          if (brp > sb.brp_max) brp = sb.brp_min;
          tq = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 600) : $urandom_range(3, 40);
          rate = sb.clock_hz / (brp * tq);
          if ($urandom_range(0, 5) == 0) rate = rate + 1;
          if (rate == 0 || rate > 64'hFFFFFF) rate = $urandom_range(1, 24'hFFFFFF);
        end
      endcase
      send_rate(rate[RATE_W-1:0]);
    end
    settle();
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_bus.valid   <= 1'b0;
    req_bus.bitrate <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    repeat (8) random_phase($urandom_range(10, 14));
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
